/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level RTL file of the sample histogram.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PSH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PSH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/psh_pkg.sv */
// Types and constants shared by the pc sample histogram modules.
`timescale 1ns / 1ps

package psh_pkg;

  localparam int INDEX_BITS  = 15;
  localparam int PROBE_LIMIT = 32;
  localparam int TABLE_SIZE  = 1 << INDEX_BITS;
  localparam int PROBE_BITS  = $clog2(PROBE_LIMIT + 1);
  localparam int PC_BITS     = 64;
  localparam int COUNT_BITS  = 32;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [PROBE_BITS-1:0] probe_cnt_t;
  typedef logic [PC_BITS-1:0]    pc_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam probe_cnt_t PROBE_END = probe_cnt_t'(PROBE_LIMIT);

  // One table slot: pc zero means empty.
  typedef struct packed {
    pc_t    pc;
    count_t count;
  } entry_t;

  // Table port request from the controller.
  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
  } tbl_req_t;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_SLOT   = 2'd1,
    OP_TOTALS = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STAT_HIT     = 3'd0,
    STAT_NEW     = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_NOPC    = 3'd3,
    STAT_FOREIGN = 3'd4,
    STAT_SLOT    = 3'd5,
    STAT_TOTALS  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_SLOT_RD,
    S_SLOT_CLR
  } state_t;

endpackage

/* hw/rtl/psh_hash.sv */
// Multiplicative hash of a sample pc down to its home slot.
`timescale 1ns / 1ps

module psh_hash (
  input  psh_pkg::pc_t  pc,
  output psh_pkg::idx_t home
);

  psh_pkg::idx_t key;
  psh_pkg::idx_t mult;

  // Only the low slot bits of the product are kept, so only the low bits
  // of both operands matter.
  assign key  = pc[psh_pkg::INDEX_BITS+1:2];
  assign mult = psh_pkg::idx_t'(psh_pkg::HASH_MULT);
  assign home = psh_pkg::idx_t'(key * mult);

endmodule

/* hw/rtl/psh_table.sv */
// Hash table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module psh_table (
  input  logic               clk,
  input  psh_pkg::tbl_req_t  req,
  output psh_pkg::entry_t    rd_data
);

  psh_pkg::entry_t mem [psh_pkg::TABLE_SIZE];
  psh_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/pc_sample_hash_histogram.sv */
// Top level of the pc sample histogram: sequencer, event totals and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Program-counter sample histogram kept in an open-addressed hash table
// (2^INDEX_BITS slots of pc and count, linear probing, up to PROBE_LIMIT
// probes). After reset the block sweeps the whole table to empty, one slot
// a cycle; busy stays high for the sweep. An operation transfers in at a
// rising edge with start high and busy low. Each transfer, except the
// unused operation code, yields exactly one result, shown for one cycle
// with out_valid high; the receiver cannot stall it, so capture it on that
// cycle. An other-thread sample, a zero-pc sample and a totals read are
// answered in the result register at the edge of the transfer and leave
// busy low; a slot read passes through S_SLOT_RD and S_SLOT_CLR; a
// recorded sample stays in S_PROBE for up to PROBE_LIMIT probes, paced by
// the table's single read port, which is read once per probe with the
// compare of each slot overlapped with the read of the next.
module pc_sample_hash_histogram (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_operation,
  input  logic [63:0]            in_sample_pc,
  input  logic                   in_other_thread,
  input  logic [14:0]            in_slot_index,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [63:0]            out_slot_pc,
  output logic [31:0]            out_slot_count,
  output logic [31:0]            out_taken_count,
  output logic [31:0]            out_foreign_count,
  output logic [31:0]            out_overflow_count,
  output logic [31:0]            out_nopc_count
);

  // Sequencer state.
  psh_pkg::state_t     state_r, state_nxt;
  psh_pkg::idx_t       clr_addr_r, clr_addr_nxt;
  psh_pkg::pc_t        pc_r, pc_nxt;
  psh_pkg::idx_t       probe_addr_r, probe_addr_nxt;
  psh_pkg::idx_t       chk_addr_r, chk_addr_nxt;
  psh_pkg::probe_cnt_t issued_r, issued_nxt;
  logic                rvalid_r, rvalid_nxt;

  // Event totals.
  psh_pkg::count_t recorded_r, recorded_nxt;
  psh_pkg::count_t foreign_r, foreign_nxt;
  psh_pkg::count_t full_r, full_nxt;
  psh_pkg::count_t nopc_r, nopc_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  psh_pkg::status_t  out_status_r, out_status_nxt;
  psh_pkg::pc_t      out_slot_pc_r, out_slot_pc_nxt;
  psh_pkg::count_t   out_slot_count_r, out_slot_count_nxt;
  psh_pkg::count_t   out_taken_r, out_taken_nxt;
  psh_pkg::count_t   out_foreign_r, out_foreign_nxt;
  psh_pkg::count_t   out_overflow_r, out_overflow_nxt;
  psh_pkg::count_t   out_nopc_r, out_nopc_nxt;

  logic              accept;
  logic              snap_before;
  psh_pkg::idx_t     home;
  psh_pkg::tbl_req_t req;
  psh_pkg::entry_t   rd_data;

  assign busy   = (state_r != psh_pkg::S_IDLE);
  assign accept = start && !busy;

  psh_hash u_hash (
    .pc   (in_sample_pc),
    .home (home)
  );

  psh_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt          = state_r;
    clr_addr_nxt       = clr_addr_r;
    pc_nxt             = pc_r;
    probe_addr_nxt     = probe_addr_r;
    chk_addr_nxt       = chk_addr_r;
    issued_nxt         = issued_r;
    rvalid_nxt         = rvalid_r;
    recorded_nxt       = recorded_r;
    foreign_nxt        = foreign_r;
    full_nxt           = full_r;
    nopc_nxt           = nopc_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_slot_pc_nxt    = '0;
    out_slot_count_nxt = '0;
    snap_before        = 1'b0;
    req                = '0;

    case (state_r)
      psh_pkg::S_CLEAR: begin
        // Sweep every slot to empty.
        req.wr_en    = 1'b1;
        req.wr_addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + psh_pkg::idx_t'(1);
        if (&clr_addr_r) begin
          state_nxt = psh_pkg::S_IDLE;
        end
      end

      psh_pkg::S_IDLE: begin
        if (accept) begin
          case (in_operation)
            psh_pkg::OP_RECORD: begin
              if (in_other_thread) begin
                foreign_nxt    = foreign_r + 32'd1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = psh_pkg::STAT_FOREIGN;
              end else if (in_sample_pc == '0) begin
                nopc_nxt       = nopc_r + 32'd1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = psh_pkg::STAT_NOPC;
              end else begin
                // Hold the pc and start probing at the home slot.
                pc_nxt         = in_sample_pc;
                probe_addr_nxt = home;
                issued_nxt     = '0;
                rvalid_nxt     = 1'b0;
                state_nxt      = psh_pkg::S_PROBE;
              end
            end
            psh_pkg::OP_SLOT: begin
              probe_addr_nxt = psh_pkg::idx_t'(in_slot_index);
              state_nxt      = psh_pkg::S_SLOT_RD;
            end
            psh_pkg::OP_TOTALS: begin
              // Report totals as they stand, then clear them.
              snap_before    = 1'b1;
              recorded_nxt   = '0;
              foreign_nxt    = '0;
              full_nxt       = '0;
              nopc_nxt       = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = psh_pkg::STAT_TOTALS;
            end
            default: begin
              // Unused code: drop the transfer without a result.
            end
          endcase
        end
      end

      psh_pkg::S_PROBE: begin
        // Read the next slot while the previous one is checked.
        if (issued_r != psh_pkg::PROBE_END) begin
          req.rd_en      = 1'b1;
          req.rd_addr    = probe_addr_r;
          probe_addr_nxt = probe_addr_r + psh_pkg::idx_t'(1);
          chk_addr_nxt   = probe_addr_r;
          issued_nxt     = issued_r + psh_pkg::probe_cnt_t'(1);
          rvalid_nxt     = 1'b1;
        end else begin
          rvalid_nxt = 1'b0;
        end
        if (rvalid_r) begin
          if (rd_data.pc == pc_r) begin
            req.wr_en          = 1'b1;
            req.wr_addr        = chk_addr_r;
            req.wr_data.pc     = pc_r;
            req.wr_data.count  = rd_data.count + 32'd1;
            recorded_nxt       = recorded_r + 32'd1;
            out_valid_nxt      = 1'b1;
            out_status_nxt     = psh_pkg::STAT_HIT;
            rvalid_nxt         = 1'b0;
            state_nxt          = psh_pkg::S_IDLE;
          end else if (rd_data.pc == '0) begin
            req.wr_en          = 1'b1;
            req.wr_addr        = chk_addr_r;
            req.wr_data.pc     = pc_r;
            req.wr_data.count  = 32'd1;
            recorded_nxt       = recorded_r + 32'd1;
            out_valid_nxt      = 1'b1;
            out_status_nxt     = psh_pkg::STAT_NEW;
            rvalid_nxt         = 1'b0;
            state_nxt          = psh_pkg::S_IDLE;
          end else if (issued_r == psh_pkg::PROBE_END) begin
            // Probes exhausted: drop as overflow.
            full_nxt       = full_r + 32'd1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = psh_pkg::STAT_FULL;
            rvalid_nxt     = 1'b0;
            state_nxt      = psh_pkg::S_IDLE;
          end
        end
      end

      psh_pkg::S_SLOT_RD: begin
        req.rd_en    = 1'b1;
        req.rd_addr  = probe_addr_r;
        chk_addr_nxt = probe_addr_r;
        state_nxt    = psh_pkg::S_SLOT_CLR;
      end

      psh_pkg::S_SLOT_CLR: begin
        req.wr_en          = 1'b1;
        req.wr_addr        = chk_addr_r;
        out_valid_nxt      = 1'b1;
        out_status_nxt     = psh_pkg::STAT_SLOT;
        out_slot_pc_nxt    = rd_data.pc;
        out_slot_count_nxt = rd_data.count;
        state_nxt          = psh_pkg::S_IDLE;
      end

      default: begin
        state_nxt = psh_pkg::S_IDLE;
      end
    endcase

    if (snap_before) begin
      out_taken_nxt    = recorded_r;
      out_foreign_nxt  = foreign_r;
      out_overflow_nxt = full_r;
      out_nopc_nxt     = nopc_r;
    end else begin
      out_taken_nxt    = recorded_nxt;
      out_foreign_nxt  = foreign_nxt;
      out_overflow_nxt = full_nxt;
      out_nopc_nxt     = nopc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psh_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      issued_r    <= '0;
      rvalid_r    <= 1'b0;
      recorded_r  <= '0;
      foreign_r   <= '0;
      full_r      <= '0;
      nopc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      issued_r    <= issued_nxt;
      rvalid_r    <= rvalid_nxt;
      recorded_r  <= recorded_nxt;
      foreign_r   <= foreign_nxt;
      full_r      <= full_nxt;
      nopc_r      <= nopc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    pc_r             <= pc_nxt;
    probe_addr_r     <= probe_addr_nxt;
    chk_addr_r       <= chk_addr_nxt;
    out_status_r     <= out_status_nxt;
    out_slot_pc_r    <= out_slot_pc_nxt;
    out_slot_count_r <= out_slot_count_nxt;
    out_taken_r      <= out_taken_nxt;
    out_foreign_r    <= out_foreign_nxt;
    out_overflow_r   <= out_overflow_nxt;
    out_nopc_r       <= out_nopc_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_pc        = out_slot_pc_r;
  assign out_slot_count     = out_slot_count_r;
  assign out_taken_count    = out_taken_r;
  assign out_foreign_count  = out_foreign_r;
  assign out_overflow_count = out_overflow_r;
  assign out_nopc_count     = out_nopc_r;

  `PSH_ASSERT_IMPLY(a_no_result_in_sweep, state_r == psh_pkg::S_CLEAR, !out_valid_r, "result during table sweep")
  `PSH_ASSERT_ALWAYS(a_probe_bound, issued_r <= psh_pkg::PROBE_END, "probe count beyond limit")
  `PSH_ASSERT_IMPLY(a_no_rw_collision, req.wr_en && req.rd_en, req.wr_addr != req.rd_addr, "read and write hit the same slot")
  `PSH_ASSERT_NEXT(a_totals_cleared, accept && in_operation == psh_pkg::OP_TOTALS, out_valid_r && recorded_r == '0 && full_r == '0, "totals read not reported or not cleared")

endmodule
